### rtl/kdtq_pkg.sv
package kdtq_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_ADD = 2'd0;
  localparam cmd_t CMD_DEL = 2'd1;
  localparam cmd_t CMD_POP = 2'd2;

  localparam status_t ST_DONE      = 3'd0;
  localparam status_t ST_PENDING   = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_NONE_DUE  = 3'd4;
  localparam status_t ST_SHUTDOWN  = 3'd5;

  // request from the command sequencer to the table walker
  typedef struct packed {
    logic start;
    logic insert;
  } tbl_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tbl_rsp_t;

endpackage

### rtl/kdtq_ram.sv
module kdtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/kdtq_table.sv
module kdtq_table #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int CONN_ID_BITS = 10,
  parameter int TIME_BITS    = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  kdtq_pkg::tbl_req_t                 req,
  input  logic [CONN_ID_BITS-1:0]            key_conn,
  input  logic [TIME_BITS-1:0]               key_dl,
  output kdtq_pkg::tbl_rsp_t                 rsp,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
  output logic [TIME_BITS-1:0]               head_dl,
  output logic [CONN_ID_BITS-1:0]            head_conn
);
  import kdtq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = TIME_BITS + CONN_ID_BITS;

  typedef enum logic [2:0] {
    T_IDLE,
    T_INS,
    T_PUT0,
    T_REM,
    T_HEAD,
    T_HEAD_LAT
  } tstate_t;

  tstate_t state;

  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] dptr;
  logic             dv;
  logic             found;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;

  logic [TIME_BITS-1:0]    rd_dl;
  logic [CONN_ID_BITS-1:0] rd_conn;
  logic                    ge;
  logic [IDX_W-1:0]        last;

  assign rd_dl   = rd_data[ENT_W-1 -: TIME_BITS];
  assign rd_conn = rd_data[CONN_ID_BITS-1:0];
  assign ge      = rd_dl >= key_dl;
  assign last    = IDX_W'(count - CNT_W'(1));

  assign rsp.busy = state != T_IDLE;
  assign rsp.done = state == T_HEAD_LAT;

  always_comb begin
    rd_addr = ptr;
    wr_en   = 1'b0;
    wr_addr = dptr;
    wr_data = rd_data;
    unique case (state)
      T_INS: begin
        // walk down from the tail, moving each later-or-equal entry up one slot
        if (dv) begin
          wr_en   = 1'b1;
          wr_addr = dptr + IDX_W'(1);
          if (!ge) begin
            wr_data = {key_dl, key_conn};
          end
        end
      end
      T_PUT0: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {key_dl, key_conn};
      end
      T_REM: begin
        // entries past the match slide down one slot
        if (dv && found) begin
          wr_en   = 1'b1;
          wr_addr = dptr - IDX_W'(1);
        end
      end
      T_HEAD: begin
        rd_addr = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      count <= '0;
      dv    <= 1'b0;
      found <= 1'b0;
    end else begin
      unique case (state)
        T_IDLE: begin
          dv    <= 1'b0;
          found <= 1'b0;
          if (req.start) begin
            if (req.insert) begin
              if (count == '0) begin
                state <= T_PUT0;
              end else begin
                ptr   <= last;
                state <= T_INS;
              end
            end else begin
              ptr   <= '0;
              state <= T_REM;
            end
          end
        end
        T_INS: begin
          dv   <= 1'b1;
          dptr <= ptr;
          if (ptr != '0) begin
            ptr <= ptr - IDX_W'(1);
          end
          if (dv) begin
            if (!ge) begin
              count <= count + CNT_W'(1);
              state <= T_HEAD;
            end else if (dptr == '0) begin
              state <= T_PUT0;
            end
          end
        end
        T_PUT0: begin
          count <= count + CNT_W'(1);
          state <= T_HEAD;
        end
        T_REM: begin
          dv   <= 1'b1;
          dptr <= ptr;
          if (ptr != last) begin
            ptr <= ptr + IDX_W'(1);
          end
          if (dv) begin
            if (rd_conn == key_conn) begin
              found <= 1'b1;
            end
            if (dptr == last) begin
              count <= count - CNT_W'(1);
              state <= T_HEAD;
            end
          end
        end
        T_HEAD: begin
          state <= T_HEAD_LAT;
        end
        T_HEAD_LAT: begin
          head_dl   <= rd_dl;
          head_conn <= rd_conn;
          state     <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  kdtq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_entries (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

### rtl/keyed_deadline_timer_queue.sv
// order: a rejected item or an unused command goes straight from the decision to its result
//   beat; delete and pop walk the table once, and a replacing add walks it twice, first a
//   removal and then an insertion
// throughput: one item at a time; the table walker moves one entry per cycle through
//   a single-port read / single-port write timer memory
// reset: stop is cleared and the table emptied at once, then every entry of the per-connection
//   pending memory is swept to zero while no input beat is taken
module keyed_deadline_timer_queue #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int CONN_ID_BITS = 10,
  parameter int TIME_BITS    = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  kdtq_pkg::cmd_t          command,
  input  logic [CONN_ID_BITS-1:0] conn_id,
  input  logic [TIME_BITS-1:0]    deadline,
  input  logic                    reschedule,
  input  logic [TIME_BITS-1:0]    current_time,
  output logic                    out_valid,
  input  logic                    out_ready,
  output kdtq_pkg::status_t       status,
  output logic [CONN_ID_BITS-1:0] popped_conn,
  output logic                    wake,
  output logic                    head_valid,
  output logic [TIME_BITS-1:0]    head_deadline
);
  import kdtq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DECIDE,
    S_REM_ADD,
    S_INS,
    S_WAIT,
    S_OUT
  } state_t;

  state_t state;

  logic                    stop;
  logic [CONN_ID_BITS-1:0] clr_idx;

  cmd_t                    cmd_r;
  logic [CONN_ID_BITS-1:0] conn_r;
  logic [TIME_BITS-1:0]    dl_r;
  logic                    resched_r;
  logic [TIME_BITS-1:0]    now_r;
  logic [CONN_ID_BITS-1:0] popped_r;
  logic                    wake_r;
  status_t                 status_r;

  tbl_req_t                tbl_req;
  tbl_rsp_t                tbl_rsp;
  logic [CNT_W-1:0]        tbl_count;
  logic [TIME_BITS-1:0]    head_dl;
  logic [CONN_ID_BITS-1:0] head_conn;
  logic [CONN_ID_BITS-1:0] key_conn;

  logic                    pend_we;
  logic [CONN_ID_BITS-1:0] pend_wa;
  logic                    pend_wd;
  logic                    pend_bit;

  logic                    tbl_empty;
  logic                    tbl_full;
  logic                    idle_before;
  status_t                 dec_status;
  logic                    dec_start;
  logic                    dec_insert;
  logic                    dec_readd;
  logic                    dec_pop;
  logic                    dec_wake;
  logic                    slot_free;

  assign cfg_ready   = 1'b1;
  assign in_ready    = state == S_IDLE;
  assign slot_free   = !out_valid || out_ready;
  assign tbl_empty   = tbl_count == '0;
  assign tbl_full    = tbl_count == CNT_W'(QUEUE_DEPTH);
  assign idle_before = tbl_empty || (head_dl > now_r);
  assign key_conn    = (cmd_r == CMD_POP) ? popped_r : conn_r;

  always_comb begin
    dec_status = ST_DONE;
    dec_start  = 1'b0;
    dec_insert = 1'b0;
    dec_readd  = 1'b0;
    dec_pop    = 1'b0;
    dec_wake   = 1'b0;
    unique case (cmd_r)
      CMD_ADD: begin
        if (stop) begin
          dec_status = ST_SHUTDOWN;
        end else if (pend_bit) begin
          if (resched_r) begin
            // old timer comes out first, so a full table still takes it
            dec_start = 1'b1;
            dec_readd = 1'b1;
            dec_wake  = idle_before && (dl_r < now_r);
          end else begin
            dec_status = ST_PENDING;
          end
        end else if (tbl_full) begin
          dec_status = ST_FULL;
        end else begin
          dec_start  = 1'b1;
          dec_insert = 1'b1;
          dec_wake   = idle_before && (dl_r < now_r);
        end
      end
      CMD_DEL: begin
        if (pend_bit) begin
          dec_start = 1'b1;
        end else begin
          dec_status = ST_NOT_FOUND;
        end
      end
      CMD_POP: begin
        if (stop) begin
          dec_status = ST_SHUTDOWN;
        end else if (!tbl_empty && (head_dl <= now_r)) begin
          dec_start = 1'b1;
          dec_pop   = 1'b1;
        end else begin
          dec_status = ST_NONE_DUE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    tbl_req = '0;
    pend_we = 1'b0;
    pend_wa = conn_r;
    pend_wd = 1'b0;
    unique case (state)
      S_CLR: begin
        pend_we = 1'b1;
        pend_wa = clr_idx;
      end
      S_DECIDE: begin
        tbl_req.start  = dec_start;
        tbl_req.insert = dec_insert;
        pend_we        = dec_start && !dec_readd;
        pend_wa        = dec_pop ? head_conn : conn_r;
        pend_wd        = dec_insert;
      end
      S_INS: begin
        tbl_req.start  = 1'b1;
        tbl_req.insert = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      stop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        stop <= cfg_data;
      end
      // S_OUT only loads the slot when it is free, so it owns out_valid there
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + CONN_ID_BITS'(1);
          if (clr_idx == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r     <= command;
            conn_r    <= conn_id;
            dl_r      <= deadline;
            resched_r <= reschedule;
            now_r     <= current_time;
            popped_r  <= '0;
            state     <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          status_r <= dec_status;
          wake_r   <= dec_wake;
          if (dec_pop) begin
            popped_r <= head_conn;
          end
          if (!dec_start) begin
            state <= S_OUT;
          end else if (dec_readd) begin
            state <= S_REM_ADD;
          end else begin
            state <= S_WAIT;
          end
        end
        S_REM_ADD: begin
          if (tbl_rsp.done) begin
            state <= S_INS;
          end
        end
        S_INS: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (tbl_rsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            status        <= status_r;
            popped_conn   <= popped_r;
            wake          <= wake_r;
            head_valid    <= !tbl_empty;
            head_deadline <= tbl_empty ? '0 : head_dl;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  kdtq_ram #(
    .WIDTH(1),
    .DEPTH(2 ** CONN_ID_BITS)
  ) u_pending (
    .clk    (clk),
    .wr_en  (pend_we),
    .wr_addr(pend_wa),
    .wr_data(pend_wd),
    .rd_addr(conn_id),
    .rd_data(pend_bit)
  );

  kdtq_table #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CONN_ID_BITS(CONN_ID_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .key_conn (key_conn),
    .key_dl   (dl_r),
    .rsp      (tbl_rsp),
    .count    (tbl_count),
    .head_dl  (head_dl),
    .head_conn(head_conn)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tbl_count <= CNT_W'(QUEUE_DEPTH))
    else $error("timer count above table depth");

  a_walk_owned: assert property (@(posedge clk) disable iff (rst)
    (tbl_rsp.busy || tbl_rsp.done) |-> (state == S_REM_ADD || state == S_WAIT))
    else $error("table walk outside a waiting state");

  a_wake_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wake) |-> (status == ST_DONE))
    else $error("wake on a rejected add");

  a_pop_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (popped_conn != '0)) |-> (status == ST_DONE))
    else $error("popped connection without a pop");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLR) |=> (state != S_CLR))
    else $error("clearing pass restarted");
`endif

endmodule
